[sv/csv_cell_splitter_classifier_unit_defines.svh]
// Assertion macros used by the checker file of the cell splitter.
`ifndef CSV_CELL_SPLITTER_CLASSIFIER_UNIT_DEFINES_SVH
`define CSV_CELL_SPLITTER_CLASSIFIER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CSVC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CSVC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/csvc_pkg.sv]
// Types and constants of the CSV cell splitter and classifier.
`default_nettype none
package csvc_pkg;

  localparam int unsigned OFF_BITS = 16;
  localparam logic [OFF_BITS-1:0] OFF_MAX = {OFF_BITS{1'b1}};

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);

  localparam logic [7:0] SEP_RESET = 8'd44;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_LO_A   = 8'h61;
  localparam logic [7:0] CH_LO_Z   = 8'h7A;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_Z   = 8'h5A;
  localparam logic [7:0] CH_LO_E   = 8'h65;
  localparam logic [7:0] CH_UP_E   = 8'h45;

  typedef enum logic [2:0] {
    CLS_LEAD,
    CLS_SIGN,
    CLS_DIGITS,
    CLS_TRAIL,
    CLS_SUFFIX,
    CLS_OTHER
  } cls_e;

  typedef enum logic [2:0] {
    KIND_EMPTY  = 3'd0,
    KIND_INT    = 3'd1,
    KIND_FLOAT  = 3'd2,
    KIND_SUFFIX = 3'd3,
    KIND_OTHER  = 3'd4
  } kind_e;

  typedef struct packed {
    logic digit;
    logic dot;
    logic expo;
    logic suffix;
    logic inq;
    logic quote;
  } flags_t;

  // One closed cell; trail asks the back end for an extra empty cell at tpos.
  typedef struct packed {
    logic [OFF_BITS-1:0] vs;
    logic [OFF_BITS-1:0] ve;
    kind_e               kind;
    logic                last;
    logic                trail;
    logic [OFF_BITS-1:0] tpos;
  } cell_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

endpackage
`default_nettype wire

[sv/csvc_front.sv]
// Front end: byte tokenizer and cell classifier, one byte per cycle while the cell queue is not full.
`default_nettype none
module csvc_front (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_valid_i,
  input  wire logic [7:0]            cfg_data_i,
  input  wire logic                  in_valid_i,
  input  wire logic [7:0]            data_byte_i,
  input  wire logic                  end_of_record_i,
  input  wire csvc_pkg::q_stat_t     q_stat_i,
  output logic                       in_stall_o,
  output logic                       push_o,
  output csvc_pkg::cell_t            cell_o
);

  logic [7:0]                    sep_q;
  logic [csvc_pkg::OFF_BITS-1:0] pos_q, pos_d;
  csvc_pkg::cls_e                cls_q, cls_d;
  csvc_pkg::flags_t              fl_q, fl_d;
  logic                          cp_q, cp_d;
  logic                          ew_q, ew_d;
  logic [csvc_pkg::OFF_BITS-1:0] qop_q, qop_d;
  logic [csvc_pkg::OFF_BITS-1:0] qcp_q, qcp_d;
  logic                          qcv_q, qcv_d;
  logic [csvc_pkg::OFF_BITS-1:0] first_q, first_d;
  logic                          found_q, found_d;
  logic [csvc_pkg::OFF_BITS-1:0] tend_q, tend_d;

  logic                          accept;
  logic                          handled;
  logic                          brk;
  logic                          blank;
  logic                          unit;
  logic                          is_digit;
  logic [csvc_pkg::OFF_BITS-1:0] pos_inc;
  logic [csvc_pkg::OFF_BITS-1:0] endp;
  csvc_pkg::cls_e                s;

  function automatic logic [csvc_pkg::OFF_BITS-1:0] sat_inc(
    input logic [csvc_pkg::OFF_BITS-1:0] v
  );
    return (v == csvc_pkg::OFF_MAX) ? v : v + 1'b1;
  endfunction

  assign in_stall_o = q_stat_i.full;
  assign accept     = in_valid_i && !in_stall_o;
  assign pos_inc    = sat_inc(pos_q);

  assign blank    = (data_byte_i == csvc_pkg::CH_SPACE) || (data_byte_i == csvc_pkg::CH_TAB);
  assign is_digit = (data_byte_i >= csvc_pkg::CH_ZERO) && (data_byte_i <= csvc_pkg::CH_NINE);
  assign unit     = ((data_byte_i >= csvc_pkg::CH_LO_A) && (data_byte_i <= csvc_pkg::CH_LO_Z)) ||
                    ((data_byte_i >= csvc_pkg::CH_UP_A) && (data_byte_i <= csvc_pkg::CH_UP_Z)) ||
                    (data_byte_i == csvc_pkg::CH_PCT);

  always_comb begin
    handled = 1'b0;
    brk     = 1'b0;
    cls_d   = cls_q;
    fl_d    = fl_q;
    cp_d    = cp_q;
    ew_d    = ew_q;
    qop_d   = qop_q;
    qcp_d   = qcp_q;
    qcv_d   = qcv_q;
    first_d = first_q;
    found_d = found_q;
    tend_d  = tend_q;
    s       = cls_q;

    // Skip a sign right after an exponent letter, whatever else it could be.
    if (ew_q) begin
      ew_d = 1'b0;
      if ((data_byte_i == csvc_pkg::CH_PLUS) || (data_byte_i == csvc_pkg::CH_MINUS)) begin
        handled = 1'b1;
      end
    end

    if (!handled && cp_q) begin
      cp_d = 1'b0;
      if (data_byte_i == csvc_pkg::CH_QUOTE) begin
        cls_d   = csvc_pkg::CLS_OTHER;
        handled = 1'b1;
      end else begin
        fl_d.inq = 1'b0;
        qcv_d    = 1'b1;
        if (cls_d != csvc_pkg::CLS_OTHER) begin
          cls_d = csvc_pkg::CLS_TRAIL;
        end
      end
    end

    if (!handled) begin
      s = cls_d;
      if (!fl_d.inq && (data_byte_i == sep_q)) begin
        brk = 1'b1;
      end else if ((data_byte_i == csvc_pkg::CH_QUOTE) && !fl_d.quote &&
                   (s == csvc_pkg::CLS_LEAD)) begin
        fl_d.inq   = 1'b1;
        fl_d.quote = 1'b1;
        qop_d      = pos_q;
      end else if ((data_byte_i == csvc_pkg::CH_QUOTE) && fl_d.inq) begin
        qcp_d = pos_q;
        if (end_of_record_i) begin
          fl_d.inq = 1'b0;
          qcv_d    = 1'b1;
          if (s != csvc_pkg::CLS_OTHER) begin
            cls_d = csvc_pkg::CLS_TRAIL;
          end
        end else begin
          cp_d = 1'b1;
        end
      end else if (s != csvc_pkg::CLS_OTHER) begin
        if (blank) begin
          if ((s == csvc_pkg::CLS_DIGITS) || (s == csvc_pkg::CLS_SIGN) ||
              (s == csvc_pkg::CLS_SUFFIX)) begin
            cls_d = csvc_pkg::CLS_TRAIL;
          end
        end else if (s == csvc_pkg::CLS_SUFFIX) begin
          if (!unit) begin
            cls_d = csvc_pkg::CLS_OTHER;
          end
        end else if (s == csvc_pkg::CLS_TRAIL) begin
          if (unit && fl_d.digit && !fl_d.suffix) begin
            cls_d       = csvc_pkg::CLS_SUFFIX;
            fl_d.suffix = 1'b1;
          end else begin
            cls_d = csvc_pkg::CLS_OTHER;
          end
        end else if (is_digit) begin
          fl_d.digit = 1'b1;
          cls_d      = csvc_pkg::CLS_DIGITS;
        end else if (((data_byte_i == csvc_pkg::CH_PLUS) ||
                      (data_byte_i == csvc_pkg::CH_MINUS)) && (s == csvc_pkg::CLS_LEAD)) begin
          cls_d = csvc_pkg::CLS_SIGN;
        end else if ((data_byte_i == csvc_pkg::CH_DOT) && !fl_d.dot) begin
          fl_d.dot = 1'b1;
          cls_d    = csvc_pkg::CLS_DIGITS;
        end else if (((data_byte_i == csvc_pkg::CH_LO_E) ||
                      (data_byte_i == csvc_pkg::CH_UP_E)) && fl_d.digit && !fl_d.expo &&
                     (s == csvc_pkg::CLS_DIGITS)) begin
          fl_d.expo = 1'b1;
          fl_d.dot  = 1'b1;
          ew_d      = 1'b1;
        end else if (unit && (s == csvc_pkg::CLS_DIGITS) && fl_d.digit) begin
          cls_d       = csvc_pkg::CLS_SUFFIX;
          fl_d.suffix = 1'b1;
        end else begin
          cls_d = csvc_pkg::CLS_OTHER;
        end
      end
    end

    if (!brk && !blank) begin
      if (!found_d) begin
        found_d = 1'b1;
        first_d = pos_q;
      end
      tend_d = pos_inc;
    end

    // Build the closed cell from the updated state.
    endp = brk ? pos_q : pos_inc;
    if (fl_d.quote) begin
      cell_o.vs = sat_inc(qop_d);
      cell_o.ve = qcv_d ? qcp_d : endp;
    end else if (found_d) begin
      cell_o.vs = first_d;
      cell_o.ve = tend_d;
    end else begin
      cell_o.vs = endp;
      cell_o.ve = endp;
    end
    if (cls_d == csvc_pkg::CLS_OTHER) begin
      cell_o.kind = csvc_pkg::KIND_OTHER;
    end else if (fl_d.suffix) begin
      cell_o.kind = csvc_pkg::KIND_SUFFIX;
    end else if (!fl_d.digit) begin
      cell_o.kind = csvc_pkg::KIND_EMPTY;
    end else if (fl_d.dot) begin
      cell_o.kind = csvc_pkg::KIND_FLOAT;
    end else begin
      cell_o.kind = csvc_pkg::KIND_INT;
    end
    cell_o.last  = end_of_record_i && !brk;
    cell_o.trail = end_of_record_i && brk;
    cell_o.tpos  = pos_inc;
    push_o       = accept && (brk || end_of_record_i);

    pos_d = pos_inc;
    if (brk || end_of_record_i) begin
      cls_d   = csvc_pkg::CLS_LEAD;
      fl_d    = '0;
      cp_d    = 1'b0;
      ew_d    = 1'b0;
      qop_d   = '0;
      qcp_d   = '0;
      qcv_d   = 1'b0;
      first_d = '0;
      found_d = 1'b0;
      tend_d  = '0;
      if (end_of_record_i) begin
        pos_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sep_q <= csvc_pkg::SEP_RESET;
    end else if (cfg_valid_i) begin
      sep_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      cls_q   <= csvc_pkg::CLS_LEAD;
      fl_q    <= '0;
      cp_q    <= 1'b0;
      ew_q    <= 1'b0;
      qop_q   <= '0;
      qcp_q   <= '0;
      qcv_q   <= 1'b0;
      first_q <= '0;
      found_q <= 1'b0;
      tend_q  <= '0;
    end else if (accept) begin
      pos_q   <= pos_d;
      cls_q   <= cls_d;
      fl_q    <= fl_d;
      cp_q    <= cp_d;
      ew_q    <= ew_d;
      qop_q   <= qop_d;
      qcp_q   <= qcp_d;
      qcv_q   <= qcv_d;
      first_q <= first_d;
      found_q <= found_d;
      tend_q  <= tend_d;
    end
  end

endmodule
`default_nettype wire

[sv/csvc_queue.sv]
// Short cell queue between the tokenizer and the output stage.
`default_nettype none
module csvc_queue (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire csvc_pkg::cell_t   cell_i,
  input  wire logic              pop_i,
  output csvc_pkg::cell_t        head_o,
  output csvc_pkg::q_stat_t      stat_o
);

  csvc_pkg::cell_t             mem_q [csvc_pkg::QDEPTH];
  logic [csvc_pkg::QPTR_W-1:0] wr_q, rd_q;
  logic [csvc_pkg::QPTR_W:0]   cnt_q, cnt_d;
  logic                        do_push, do_pop;

  assign stat_o.empty = (cnt_q == '0);
  assign stat_o.full  = (cnt_q == (csvc_pkg::QPTR_W + 1)'(csvc_pkg::QDEPTH));
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign head_o       = mem_q[rd_q];

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= cell_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= rd_q + 1'b1;
      end
      cnt_q <= cnt_d;
    end
  end

endmodule
`default_nettype wire

[sv/csvc_back.sv]
// Back end: output register that sends each queued cell, plus the trailing empty cell.
`default_nettype none
module csvc_back (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire csvc_pkg::cell_t               head_i,
  input  wire csvc_pkg::q_stat_t             q_stat_i,
  output logic                               pop_o,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [csvc_pkg::OFF_BITS-1:0]      value_start_o,
  output logic [csvc_pkg::OFF_BITS-1:0]      value_end_o,
  output logic [2:0]                         value_kind_o,
  output logic                               last_cell_o
);

  csvc_pkg::cell_t cell_q;
  logic            valid_q;
  logic            second_q;
  logic            advance;
  logic            to_second;

  assign advance   = !valid_q || !out_stall_i;
  assign to_second = valid_q && cell_q.trail && !second_q;
  assign pop_o     = advance && !to_second && !q_stat_i.empty;

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cell_q <= head_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= 1'b0;
      second_q <= 1'b0;
    end else if (advance) begin
      if (to_second) begin
        second_q <= 1'b1;
      end else begin
        valid_q  <= !q_stat_i.empty;
        second_q <= 1'b0;
      end
    end
  end

  // The second beat of a trailing cell is the empty cell at the record length.
  assign out_valid_o   = valid_q;
  assign value_start_o = second_q ? cell_q.tpos : cell_q.vs;
  assign value_end_o   = second_q ? cell_q.tpos : cell_q.ve;
  assign value_kind_o  = second_q ? csvc_pkg::KIND_EMPTY : cell_q.kind;
  assign last_cell_o   = second_q ? 1'b1 : cell_q.last;

endmodule
`default_nettype wire

[sv/csv_cell_splitter_classifier_unit.sv]
// Path: a cell passes from the tokenizer through the cell queue into the output
// register; a trailing empty cell follows as a second beat.
// Throughput: one byte per cycle in, one cell beat per cycle out while out_stall_i is
// low; a record that ends on a separator gives two beats, the four-entry cell queue
// absorbs the extra one. Input stalls only while the cell queue is full.
// Reset: asynchronous, active low; clears the tokenizer, queue and output register
// and sets the separator to a comma.
`default_nettype none
module csv_cell_splitter_classifier_unit (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [7:0]                    cfg_data_i,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [7:0]                    data_byte_i,
  input  wire logic                          end_of_record_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [csvc_pkg::OFF_BITS-1:0]      value_start_o,
  output logic [csvc_pkg::OFF_BITS-1:0]      value_end_o,
  output logic [2:0]                         value_kind_o,
  output logic                               last_cell_o
);

  csvc_pkg::cell_t   push_cell;
  csvc_pkg::cell_t   head_cell;
  csvc_pkg::q_stat_t q_stat;
  logic              push;
  logic              pop;

  assign cfg_ready_o = 1'b1;

  csvc_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .data_byte_i     (data_byte_i),
    .end_of_record_i (end_of_record_i),
    .q_stat_i        (q_stat),
    .in_stall_o      (in_stall_o),
    .push_o          (push),
    .cell_o          (push_cell)
  );

  csvc_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cell_i (push_cell),
    .pop_i  (pop),
    .head_o (head_cell),
    .stat_o (q_stat)
  );

  csvc_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head_cell),
    .q_stat_i      (q_stat),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .value_start_o (value_start_o),
    .value_end_o   (value_end_o),
    .value_kind_o  (value_kind_o),
    .last_cell_o   (last_cell_o)
  );

endmodule
`default_nettype wire

[sv/csvc_checker.sv]
// Port-level checker for the cell splitter, bound to the top level.
`default_nettype none
`include "csv_cell_splitter_classifier_unit_defines.svh"
module csvc_checker (
  input wire logic                     clk_i,
  input wire logic                     rst_ni,
  input wire logic                     out_valid_o,
  input wire logic                     out_stall_i,
  input wire logic [csvc_pkg::OFF_BITS-1:0] value_start_o,
  input wire logic [csvc_pkg::OFF_BITS-1:0] value_end_o,
  input wire logic [2:0]               value_kind_o,
  input wire logic                     last_cell_o
);

  // Hold a stalled beat.
  `CSVC_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i,
    out_valid_o && $stable(value_start_o) && $stable(value_end_o) &&
    $stable(value_kind_o) && $stable(last_cell_o), "stalled output beat changed")

  `CSVC_ASSERT_IMP(a_span_order, out_valid_o, value_start_o <= value_end_o,
    "cell span starts after its end")

  `CSVC_ASSERT_IMP(a_kind_range, out_valid_o, value_kind_o <= 3'(csvc_pkg::KIND_OTHER),
    "cell kind out of range")

endmodule

bind csv_cell_splitter_classifier_unit csvc_checker u_csvc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .value_start_o (value_start_o),
  .value_end_o   (value_end_o),
  .value_kind_o  (value_kind_o),
  .last_cell_o   (last_cell_o)
);
`default_nettype wire
